// ----- rtl/ttt_pkg.sv -----
// Package for the transmitter tally table: outcome and type codes,
// register indexes, reset values and the table entry type.
// No dependencies.
package ttt_pkg;

  // Default table depth
  localparam int DEF_TABLE_ENTRIES = 32;

  // Field widths
  localparam int ADDR_W    = 48;
  localparam int FRAMES_W  = 32;
  localparam int RSSI_W    = 8;
  localparam int LEN_W     = 12;
  localparam int OUTCOME_W = 3;
  localparam int INDEX_W   = 5;
  localparam int USED_W    = 6;
  localparam int COUNT_W   = 32;
  localparam int TYPE_W    = 2;
  localparam int CFG_IDX_W = 1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CAPTURE_ENABLE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_LENGTH     = 1'b1;

  // Reset value of the minimum tabled length
  localparam logic [LEN_W-1:0] MIN_LEN_RESET = 12'd16;

  // Actions
  localparam logic ACT_FRAME = 1'b0;
  localparam logic ACT_CLEAR = 1'b1;

  // Frame types
  localparam logic [TYPE_W-1:0] FT_MGMT  = 2'd0;
  localparam logic [TYPE_W-1:0] FT_DATA  = 2'd1;
  localparam logic [TYPE_W-1:0] FT_CTRL  = 2'd2;
  localparam logic [TYPE_W-1:0] FT_OTHER = 2'd3;

  // Outcome codes
  localparam logic [OUTCOME_W-1:0] OC_IGNORED  = 3'd0;
  localparam logic [OUTCOME_W-1:0] OC_COUNTED  = 3'd1;
  localparam logic [OUTCOME_W-1:0] OC_HIT      = 3'd2;
  localparam logic [OUTCOME_W-1:0] OC_INSERTED = 3'd3;
  localparam logic [OUTCOME_W-1:0] OC_FULL     = 3'd4;
  localparam logic [OUTCOME_W-1:0] OC_CLEARED  = 3'd5;

  // One table entry
  typedef struct packed {
    logic [ADDR_W-1:0]          addr;
    logic [FRAMES_W-1:0]        frames;
    logic signed [RSSI_W-1:0]   rssi;
  } entry_t;

endpackage

// ----- rtl/transmitter_tally_table.sv -----
// Transmitter tally table: per-type frame counters plus a searched table
// of transmitter addresses. Depends on ttt_pkg.
//
// Takes one frame descriptor (or a clear action) at a time and returns one
// result word for each. A single 48-bit address comparator walks the table
// memory one slot per cycle from slot 0, so the item time depends on how far
// the search goes: an ignored, cleared or untabled frame needs no search, a
// hit stops at the matching slot, an insert walks all entries_used slots
// (none when the table is empty) and a drop on a full table walks every slot.
// in_ready is high only between items. A finished result sits in an output
// register until taken, while the next item may already be accepted. The
// table needs no clearing pass: slots at or above entries_used are never
// compared.
module transmitter_tally_table #(
  parameter int TABLE_ENTRIES = ttt_pkg::DEF_TABLE_ENTRIES
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // configuration
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [ttt_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [ttt_pkg::LEN_W-1:0]           cfg_data,
  // input words
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                in_action,
  input  logic [ttt_pkg::TYPE_W-1:0]          in_frame_type,
  input  logic [ttt_pkg::LEN_W-1:0]           in_frame_length,
  input  logic [ttt_pkg::ADDR_W-1:0]          in_transmitter_address,
  input  logic signed [ttt_pkg::RSSI_W-1:0]   in_signal_strength,
  // result words
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [ttt_pkg::OUTCOME_W-1:0]       out_outcome,
  output logic [ttt_pkg::INDEX_W-1:0]         out_entry_index,
  output logic [ttt_pkg::FRAMES_W-1:0]        out_entry_frames,
  output logic signed [ttt_pkg::RSSI_W-1:0]   out_entry_best_rssi,
  output logic [ttt_pkg::USED_W-1:0]          out_entries_used,
  output logic [ttt_pkg::COUNT_W-1:0]         out_mgmt_count,
  output logic [ttt_pkg::COUNT_W-1:0]         out_data_count,
  output logic [ttt_pkg::COUNT_W-1:0]         out_ctrl_count,
  output logic [ttt_pkg::COUNT_W-1:0]         out_other_count
);

  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(TABLE_ENTRIES);

  // Sequencer states
  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_SEARCH = 3'd1;
  localparam logic [2:0] ST_UPDATE = 3'd2;
  localparam logic [2:0] ST_INSERT = 3'd3;
  localparam logic [2:0] ST_DONE   = 3'd4;

  logic [2:0]                           state_r, state_nxt;

  // Configuration
  logic                                 cap_en_r;
  logic [ttt_pkg::LEN_W-1:0]            min_len_r;

  // Counters and occupancy
  logic [ttt_pkg::COUNT_W-1:0]          type_cnt_r [4];
  logic [CNT_W-1:0]                     occ_r;

  // Latched item
  logic [ttt_pkg::ADDR_W-1:0]           addr_r;
  logic signed [ttt_pkg::RSSI_W-1:0]    rssi_r;

  // Table memory and its read port
  ttt_pkg::entry_t                      tbl_mem_r [TABLE_ENTRIES];
  ttt_pkg::entry_t                      rd_data_r;
  logic [IDX_W-1:0]                     rd_addr;
  logic                                 rd_en;
  logic                                 wr_en;
  logic [IDX_W-1:0]                     wr_addr;
  ttt_pkg::entry_t                      wr_data;

  // Search pointer
  logic [IDX_W-1:0]                     cmp_idx_r;
  logic                                 match;
  logic                                 last_slot;

  // Result being built
  logic [ttt_pkg::OUTCOME_W-1:0]        res_outcome_r;
  logic [IDX_W-1:0]                     res_idx_r;
  logic [ttt_pkg::FRAMES_W-1:0]         res_frames_r;
  logic signed [ttt_pkg::RSSI_W-1:0]    res_rssi_r;

  // Output register
  logic                                 out_valid_r;
  logic [ttt_pkg::OUTCOME_W-1:0]        out_outcome_r;
  logic [ttt_pkg::INDEX_W-1:0]          out_index_r;
  logic [ttt_pkg::FRAMES_W-1:0]         out_frames_r;
  logic signed [ttt_pkg::RSSI_W-1:0]    out_rssi_r;
  logic [ttt_pkg::USED_W-1:0]           out_used_r;
  logic [ttt_pkg::COUNT_W-1:0]          out_cnt_r [4];

  logic                                 in_fire;
  logic                                 out_free;
  logic                                 tabled;
  logic [ttt_pkg::FRAMES_W-1:0]         upd_frames;
  logic signed [ttt_pkg::RSSI_W-1:0]    upd_rssi;

  assign in_ready  = (state_r == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign in_fire   = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;

  assign tabled = ((in_frame_type == ttt_pkg::FT_MGMT) ||
                   (in_frame_type == ttt_pkg::FT_DATA)) &&
                  (in_frame_length >= min_len_r);

  // Compare unit: one slot per cycle
  assign match     = (rd_data_r.addr == addr_r);
  assign last_slot = ((CNT_W'(cmp_idx_r) + CNT_W'(1)) == occ_r);

  // Hit update: saturating count, strongest signal
  assign upd_frames = (&rd_data_r.frames) ? rd_data_r.frames
                                          : rd_data_r.frames + 1'b1;
  assign upd_rssi   = (rssi_r > rd_data_r.rssi) ? rssi_r : rd_data_r.rssi;

  // Read address: slot 0 on accept, next slot while searching
  assign rd_addr = (state_r == ST_SEARCH) ? IDX_W'(cmp_idx_r + 1'b1) : '0;
  assign rd_en   = (state_r == ST_IDLE) || ((state_r == ST_SEARCH) && !match);

  // Memory write
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = cmp_idx_r;
    wr_data = '{addr: addr_r, frames: upd_frames, rssi: upd_rssi};
    if (state_r == ST_UPDATE) begin
      wr_en = 1'b1;
    end else if (state_r == ST_INSERT) begin
      wr_en   = 1'b1;
      wr_addr = IDX_W'(occ_r);
      wr_data = '{addr: addr_r, frames: ttt_pkg::FRAMES_W'(1), rssi: rssi_r};
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      tbl_mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= tbl_mem_r[rd_addr];
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          if (in_action == ttt_pkg::ACT_CLEAR || !cap_en_r || !tabled) begin
            state_nxt = ST_DONE;
          end else if (occ_r == '0) begin
            state_nxt = ST_INSERT;
          end else begin
            state_nxt = ST_SEARCH;
          end
        end
      end
      ST_SEARCH: begin
        if (match) begin
          state_nxt = ST_UPDATE;
        end else if (last_slot) begin
          state_nxt = (occ_r < FULL_CNT) ? ST_INSERT : ST_DONE;
        end
      end
      ST_UPDATE: state_nxt = ST_DONE;
      ST_INSERT: state_nxt = ST_DONE;
      ST_DONE:   if (out_free) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cap_en_r    <= 1'b0;
      min_len_r   <= ttt_pkg::MIN_LEN_RESET;
      occ_r       <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < 4; i++) begin
        type_cnt_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;

      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          ttt_pkg::REG_CAPTURE_ENABLE: cap_en_r  <= cfg_data[0];
          ttt_pkg::REG_MIN_LENGTH:     min_len_r <= cfg_data;
          default: ;
        endcase
      end

      if (in_fire) begin
        if (in_action == ttt_pkg::ACT_CLEAR) begin
          occ_r <= '0;
          for (int i = 0; i < 4; i++) begin
            type_cnt_r[i] <= '0;
          end
        end else if (cap_en_r) begin
          type_cnt_r[in_frame_type] <= type_cnt_r[in_frame_type] + 1'b1;
        end
      end

      if (state_r == ST_INSERT) begin
        occ_r <= occ_r + 1'b1;
      end

      // New word loads, else a taken word leaves
      if (state_r == ST_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      addr_r       <= in_transmitter_address;
      rssi_r       <= in_signal_strength;
      cmp_idx_r    <= '0;
      res_idx_r    <= '0;
      res_frames_r <= '0;
      res_rssi_r   <= '0;
      if (in_action == ttt_pkg::ACT_CLEAR) begin
        res_outcome_r <= ttt_pkg::OC_CLEARED;
      end else if (!cap_en_r) begin
        res_outcome_r <= ttt_pkg::OC_IGNORED;
      end else begin
        res_outcome_r <= ttt_pkg::OC_COUNTED;
      end
    end

    unique case (state_r)
      ST_SEARCH: begin
        if (!match) begin
          if (!last_slot) begin
            cmp_idx_r <= cmp_idx_r + 1'b1;
          end else if (occ_r == FULL_CNT) begin
            res_outcome_r <= ttt_pkg::OC_FULL;
          end
        end
      end
      ST_UPDATE: begin
        res_outcome_r <= ttt_pkg::OC_HIT;
        res_idx_r     <= cmp_idx_r;
        res_frames_r  <= upd_frames;
        res_rssi_r    <= upd_rssi;
      end
      ST_INSERT: begin
        res_outcome_r <= ttt_pkg::OC_INSERTED;
        res_idx_r     <= IDX_W'(occ_r);
        res_frames_r  <= ttt_pkg::FRAMES_W'(1);
        res_rssi_r    <= rssi_r;
      end
      default: ;
    endcase

    // Load the output word
    if (state_r == ST_DONE && out_free) begin
      out_outcome_r <= res_outcome_r;
      out_index_r   <= ttt_pkg::INDEX_W'(res_idx_r);
      out_frames_r  <= res_frames_r;
      out_rssi_r    <= res_rssi_r;
      out_used_r    <= ttt_pkg::USED_W'(occ_r);
      for (int i = 0; i < 4; i++) begin
        out_cnt_r[i] <= type_cnt_r[i];
      end
    end
  end

  assign out_valid           = out_valid_r;
  assign out_outcome         = out_outcome_r;
  assign out_entry_index     = out_index_r;
  assign out_entry_frames    = out_frames_r;
  assign out_entry_best_rssi = out_rssi_r;
  assign out_entries_used    = out_used_r;
  assign out_mgmt_count      = out_cnt_r[0];
  assign out_data_count      = out_cnt_r[1];
  assign out_ctrl_count      = out_cnt_r[2];
  assign out_other_count     = out_cnt_r[3];

  // Checks
  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= FULL_CNT)
    else $error("occupancy beyond table depth");

  a_search_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SEARCH) |-> (CNT_W'(cmp_idx_r) < occ_r))
    else $error("search pointer past occupied slots");

  a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_action == ttt_pkg::ACT_CLEAR) |=> (occ_r == '0))
    else $error("clear left table occupied");

  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_DONE))
    else $error("result word raised outside done state");

  a_insert_has_room: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_INSERT) |-> (occ_r < FULL_CNT))
    else $error("insert into full table");

endmodule
